// ----- hdl/fpa_pkg.sv -----
// Package for the fixed-point ALU: mode codes, widths, queue entry type.
// No dependencies.
package fpa_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 8;
  localparam int unsigned DivSteps = DataW + FracBits;
  localparam int unsigned DivW     = DataW + FracBits;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [3:0] {
    ModeAdd = 4'd0, ModeSub = 4'd1, ModeMul = 4'd2, ModeDiv = 4'd3,
    ModeLt = 4'd4, ModeGt = 4'd5, ModeLe = 4'd6, ModeGe = 4'd7,
    ModeEq = 4'd8, ModeNe = 4'd9, ModeMin = 4'd10, ModeMax = 4'd11,
    ModeToInt = 4'd12, ModeFromInt = 4'd13, ModeInc = 4'd14, ModeDec = 4'd15
  } mode_e;

  typedef enum logic [1:0] {
    ClsSimple = 2'd0, ClsMul = 2'd1, ClsDiv = 2'd2
  } cls_e;

  // One classified word passed from front to back.
  typedef struct packed {
    cls_e              cls;
    logic signed [DataW-1:0] simple_res;
    logic              cmp;
    logic              dz;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
  } entry_t;

endpackage

// ----- hdl/fpa_front.sv -----
// Front end: accept a word, evaluate the simple modes, classify the rest.
// Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3:0]              mode_i,
  input  logic signed [DataW-1:0] operand_a_i,
  input  logic signed [DataW-1:0] operand_b_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output entry_t                  q_entry_o
);

  entry_t ent;
  entry_t mem_q [QDepth];
  logic   wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  // Classify and evaluate the simple modes
  always_comb begin
    ent = '0;
    ent.a = operand_a_i;
    ent.b = operand_b_i;
    ent.cls = ClsSimple;
    unique case (mode_e'(mode_i))
      ModeAdd: ent.simple_res = operand_a_i + operand_b_i;
      ModeSub: ent.simple_res = operand_a_i - operand_b_i;
      ModeMul: ent.cls = ClsMul;
      ModeDiv: begin
        if (operand_b_i == '0) ent.dz = 1'b1;
        else ent.cls = ClsDiv;
      end
      ModeLt: ent.cmp = operand_a_i < operand_b_i;
      ModeGt: ent.cmp = operand_a_i > operand_b_i;
      ModeLe: ent.cmp = operand_a_i <= operand_b_i;
      ModeGe: ent.cmp = operand_a_i >= operand_b_i;
      ModeEq: ent.cmp = operand_a_i == operand_b_i;
      ModeNe: ent.cmp = operand_a_i != operand_b_i;
      ModeMin: ent.simple_res = (operand_a_i > operand_b_i) ? operand_b_i : operand_a_i;
      ModeMax: ent.simple_res = (operand_a_i < operand_b_i) ? operand_b_i : operand_a_i;
      ModeToInt: ent.simple_res = operand_a_i >>> FracBits;
      ModeFromInt: ent.simple_res = operand_a_i <<< FracBits;
      ModeInc: ent.simple_res = operand_a_i + 32'sd1;
      ModeDec: ent.simple_res = operand_a_i - 32'sd1;
      default: ent.simple_res = '0;
    endcase
  end

  // Two-entry queue toward the back end
  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_entry_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/fpa_back.sv -----
// Back end: pipelined multiply and radix-2 divide, one stage per quotient bit.
// Depends on fpa_pkg.
module fpa_back import fpa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  output logic                    q_ready_o,
  input  entry_t                  q_entry_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] result_value_o,
  output logic                    compare_true_o,
  output logic                    divide_by_zero_o
);

  localparam int unsigned NSt = DivSteps + 2;

  typedef struct packed {
    cls_e                      cls;
    logic signed [DataW-1:0]   res;
    logic                      cmp;
    logic                      dz;
    logic [DivW-1:0]           rem_num;
    logic [DataW:0]            part;
    logic [DataW-1:0]          den;
    logic                      neg;
  } stg_t;

  stg_t st_q [NSt];
  stg_t st_d [NSt];
  logic vld_q [NSt];
  logic adv;
  stg_t s0;
  logic signed [2*DataW-1:0] prod;
  logic [DataW-1:0] mag_a, mag_b;
  logic [DataW:0] tr [DivSteps];

  // The whole pipe moves together; stall when the output holds
  assign adv = !vld_q[NSt-1] || out_ready_i;
  assign q_ready_o = adv;

  // Stage 0 setup: operand magnitudes and the 64-bit product
  always_comb begin
    mag_a = q_entry_i.a[DataW-1] ? DataW'(-q_entry_i.a) : DataW'(q_entry_i.a);
    mag_b = q_entry_i.b[DataW-1] ? DataW'(-q_entry_i.b) : DataW'(q_entry_i.b);
    prod = 64'(q_entry_i.a) * 64'(q_entry_i.b);
    s0 = '0;
    s0.cls = q_entry_i.cls;
    s0.res = q_entry_i.simple_res;
    s0.cmp = q_entry_i.cmp;
    s0.dz = q_entry_i.dz;
    s0.neg = q_entry_i.a[DataW-1] ^ q_entry_i.b[DataW-1];
    s0.den = mag_b;
    s0.rem_num = {mag_a, {FracBits{1'b0}}};
    if (q_entry_i.cls == ClsMul) begin
      // floor of the shifted product; part flags dropped nonzero bits
      s0.neg = prod[2*DataW-1];
      s0.rem_num = DivW'(0);
      s0.res = DataW'(prod >>> FracBits);
      s0.part = {1'b0, prod[FracBits-1:0] != '0, {(DataW-1){1'b0}}};
    end
  end

  // Next value of every stage: multiply fix-up, divide steps, sign fix-up
  always_comb begin
    st_d[0] = s0;
    for (int i = 1; i < NSt; i++) st_d[i] = st_q[i-1];
    // Multiply: floor shift plus one when negative and bits were dropped
    if (st_q[0].cls == ClsMul && st_q[0].neg && st_q[0].part[DataW-1]) begin
      st_d[1].res = st_q[0].res + 32'sd1;
    end
    for (int i = 1; i <= DivSteps; i++) begin
      tr[i-1] = {st_q[i-1].part[DataW-1:0], st_q[i-1].rem_num[DivW-1]};
      if (st_q[i-1].cls == ClsDiv) begin
        st_d[i].rem_num = {st_q[i-1].rem_num[DivW-2:0],
                           tr[i-1] >= {1'b0, st_q[i-1].den}};
        st_d[i].part = (tr[i-1] >= {1'b0, st_q[i-1].den}) ?
                       tr[i-1] - {1'b0, st_q[i-1].den} : tr[i-1];
      end
    end
    if (st_q[NSt-2].cls == ClsDiv) begin
      st_d[NSt-1].res = st_q[NSt-2].neg ? -DataW'(st_q[NSt-2].rem_num)
                                        : DataW'(st_q[NSt-2].rem_num);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSt; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= q_valid_i;
      for (int i = 1; i < NSt; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Advance the stage registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NSt; i++) st_q[i] <= st_d[i];
    end
  end

  assign out_valid_o = vld_q[NSt-1];
  assign result_value_o = st_q[NSt-1].res;
  assign compare_true_o = st_q[NSt-1].cmp;
  assign divide_by_zero_o = st_q[NSt-1].dz;

endmodule

// ----- hdl/fixed_point_alu.sv -----
// Top level of the fixed-point ALU: front classifier, queue, back pipeline.
// Depends on fpa_pkg, fpa_front, fpa_back.
//
//  channel | signals                                      | dir
//  in      | in_valid_i in_ready_o mode_i operand_a/b_i   | in
//  out     | out_valid_o out_ready_i result_value_o
//          | compare_true_o divide_by_zero_o               | out
//
// One word per cycle while the output is not stalled; every result passes
// through the queue and then through the 42-stage back pipe (setup, 40
// restoring divide steps, sign fix-up) before it shows on the output.
// Reset clears the valid flags and the queue pointers. A stalled output
// freezes the back pipe; the two-entry queue then fills and drops in_ready_o.
module fixed_point_alu import fpa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3:0]              mode_i,
  input  logic signed [DataW-1:0] operand_a_i,
  input  logic signed [DataW-1:0] operand_b_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] result_value_o,
  output logic                    compare_true_o,
  output logic                    divide_by_zero_o
);

  logic   q_valid, q_ready;
  entry_t q_entry;

  fpa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .operand_a_i, .operand_b_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_entry_o(q_entry)
  );

  fpa_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_entry_i(q_entry),
    .out_valid_o, .out_ready_i, .result_value_o, .compare_true_o, .divide_by_zero_o
  );

endmodule
